### design/poly1305_mac_defines.svh
// Assertion macros shared by the Poly1305 MAC design files.
`ifndef POLY1305_MAC_DEFINES_SVH
`define POLY1305_MAC_DEFINES_SVH

// Checks a condition at every rising clock edge outside reset.
`define P1305_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Checks that a trigger condition is followed by a result in the next cycle.
`define P1305_NEXT(label, trig, res, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (res)) \
      else $error(msg);

`endif

### design/p1305_pkg.sv
// Shared types and constants of the Poly1305 MAC.
`default_nettype none
package p1305_pkg;

   localparam int LIMB_W  = 26;              // limb width of the multiplier operands
   localparam int LIMBS   = 5;               // limbs per 130-bit operand
   localparam int ACC_W   = LIMB_W * LIMBS;  // accumulator width
   localparam int H_W     = ACC_W + 1;       // accumulator plus padded block
   localparam int R_W     = 124;             // clamped multiplier width
   localparam int A_W     = LIMB_W + 1;      // multiplier operand from h
   localparam int B_W     = LIMB_W + 3;      // multiplier operand from r or 5*r
   localparam int PROD_W  = A_W + B_W;       // product width
   localparam int COL_W   = PROD_W + 4;      // column sum of five products plus carry
   localparam int CARRY_W = COL_W - LIMB_W;  // carry out of the last column

   localparam logic [63:0] CLAMP_LOW  = 64'h0FFF_FFFC_0FFF_FFFF;
   localparam logic [63:0] CLAMP_HIGH = 64'h0FFF_FFFC_0FFF_FFFC;
   localparam logic [ACC_W-1:0] P_MOD =
      130'h3_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFB;
   localparam logic [7:0] PAD_BYTE    = 8'h01;
   localparam logic [4:0] BLOCK_BYTES = 5'd16;
   localparam logic [2:0] LAST_LIMB   = 3'd4;

   // Control word that travels with one partial product through the multiplier.
   typedef struct packed {
      logic       vld;      // a product is issued
      logic       col_end;  // last product of its output column
      logic [2:0] row;      // limb of h
      logic [2:0] col;      // output column
   } mul_ctl_type;

endpackage
`default_nettype wire

### design/p1305_mul.sv
// Shared limb multiplier: selects one h limb and one r (or 5*r) limb, registers the product.
`default_nettype none
module p1305_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [p1305_pkg::H_W-1:0]    h,
   input  wire logic [p1305_pkg::R_W-1:0]    r,
   input  wire p1305_pkg::mul_ctl_type       ctl_in,
   output logic [p1305_pkg::PROD_W-1:0]      prod,
   output p1305_pkg::mul_ctl_type            ctl_out
);
   import p1305_pkg::*;

   logic [ACC_W-1:0]  r_pad;
   logic [A_W-1:0]    a_sel;
   logic [LIMB_W-1:0] r_sel;
   logic [B_W-1:0]    b_sel;
   logic [3:0]        j_wide;
   logic [2:0]        j_idx;
   logic              fold;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   mul_ctl_type       ctl_ff;

   assign r_pad = ACC_W'(r);

   // Column k takes h[i] * r[k-i]; terms with i > k wrap past 2^130 and use 5*r.
   assign fold   = ctl_in.row > ctl_in.col;
   assign j_wide = fold ? ({1'b0, ctl_in.col} + 4'd5 - {1'b0, ctl_in.row})
                        : ({1'b0, ctl_in.col} - {1'b0, ctl_in.row});
   assign j_idx  = j_wide[2:0];

   always_comb begin
      case (ctl_in.row)
         3'd0: a_sel = {1'b0, h[0*LIMB_W +: LIMB_W]};
         3'd1: a_sel = {1'b0, h[1*LIMB_W +: LIMB_W]};
         3'd2: a_sel = {1'b0, h[2*LIMB_W +: LIMB_W]};
         3'd3: a_sel = {1'b0, h[3*LIMB_W +: LIMB_W]};
         3'd4: a_sel = h[H_W-1 -: A_W];
         default: a_sel = '0;
      endcase
      case (j_idx)
         3'd0: r_sel = r_pad[0*LIMB_W +: LIMB_W];
         3'd1: r_sel = r_pad[1*LIMB_W +: LIMB_W];
         3'd2: r_sel = r_pad[2*LIMB_W +: LIMB_W];
         3'd3: r_sel = r_pad[3*LIMB_W +: LIMB_W];
         3'd4: r_sel = r_pad[4*LIMB_W +: LIMB_W];
         default: r_sel = '0;
      endcase
      b_sel   = fold ? ((B_W'(r_sel) << 2) + B_W'(r_sel)) : B_W'(r_sel);
      prod_in = PROD_W'(a_sel) * PROD_W'(b_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      prod_ff <= prod_in;
   end

   assign prod    = prod_ff;
   assign ctl_out = ctl_ff;

endmodule
`default_nettype wire

### design/poly1305_mac.sv
// Top level of the Poly1305 MAC: key registers, block padding, sequencer and tag output.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_tvalid/tready     req_tdata, req_tlast (last block)
//   rsp      out        rsp_tvalid/tready     rsp_tdata (128-bit tag)
//   csr      in         csr_we                csr_addr, csr_wdata
//
// A request with one or more valid bytes passes through these states: ST_IDLE pads the
// block and adds it to the accumulator, ST_MUL issues the limb products of all five
// columns on the single shared 27x29 multiplier, ST_DRAIN drains its output register,
// and ST_FOLD1, ST_FOLD2 and ST_FINAL reduce modulo 2^130-5. A last request then loads
// the tag into the output register in ST_EMIT, waiting there while that register is full.
// A request with no valid bytes skips the multiply and the reductions (plus the tag load if it is last).
// Reset is synchronous and clears the key registers, the accumulator and all control.
// The block takes a new request while a tag still waits in the output register.
`default_nettype none
`include "poly1305_mac_defines.svh"
module poly1305_mac (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // req_tdata from bit 0: block_low[63:0], block_high[63:0], byte_count[4:0], zero fill
   input  wire logic [135:0] req_tdata,
   input  wire logic         req_tlast,
   // Response channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // rsp_tdata from bit 0: tag_low[63:0], tag_high[63:0]
   output logic [127:0]      rsp_tdata,
   // Configuration write port.
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_addr,
   input  wire logic [63:0]  csr_wdata
);
   import p1305_pkg::*;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_R_LOW  = 2'd0,
      REG_R_HIGH = 2'd1,
      REG_S_LOW  = 2'd2,
      REG_S_HIGH = 2'd3
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_FOLD1,
      ST_FOLD2,
      ST_FINAL,
      ST_EMIT
   } state_type;

   // Key registers. The r half is clamped on its way to the multiplier.
   logic [63:0] r_low_ff, r_high_ff, s_low_ff, s_high_ff;

   state_type          state_ff;
   logic               last_ff;
   logic [2:0]         row_ff, col_ff;
   logic [ACC_W-1:0]   acc_ff;       // accumulator, always below p between requests
   logic [H_W-1:0]     h_ff;         // accumulator plus the padded block
   logic [COL_W-1:0]   col_acc_ff;   // running column sum, then carry into the next column
   logic [ACC_W-1:0]   red_ff;       // product limbs as the columns complete
   logic [H_W-1:0]     fold_ff;      // value during the final reductions
   logic               rsp_tvalid_ff;
   logic [127:0]       rsp_tdata_ff;

   logic [4:0]         count_sat;
   logic [135:0]       msg_pad;
   logic [H_W-1:0]     h_in;
   logic [R_W-1:0]     r_clamped;
   logic [127:0]       tag;
   logic [COL_W-1:0]   col_sum;
   logic [H_W-1:0]     carry_fold;
   logic [H_W-1:0]     plus_five;
   logic               out_free;
   mul_ctl_type        mul_ctl_in;
   mul_ctl_type        mul_ctl_out;
   logic [PROD_W-1:0]  mul_prod;

   // Configuration writes. Indexes are all in range for a two-bit address.
   always_ff @(posedge clock) begin
      if (reset) begin
         r_low_ff  <= '0;
         r_high_ff <= '0;
         s_low_ff  <= '0;
         s_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_R_LOW:  r_low_ff  <= csr_wdata;
            REG_R_HIGH: r_high_ff <= csr_wdata;
            REG_S_LOW:  s_low_ff  <= csr_wdata;
            REG_S_HIGH: s_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign r_clamped = R_W'({r_high_ff & CLAMP_HIGH, r_low_ff & CLAMP_LOW});

   // Counts above sixteen are treated as a full block.
   assign count_sat = (req_tdata[132:128] > BLOCK_BYTES) ? BLOCK_BYTES : req_tdata[132:128];

   // Keep the valid bytes, place the pad byte right after them, zero the rest. A full
   // block gets its pad byte at position sixteen, which is bit 128 of the sum.
   always_comb begin
      for (int b = 0; b < 17; b++) begin
         if (5'(b) < count_sat) begin
            msg_pad[8*b +: 8] = req_tdata[8*b +: 8];
         end else if (5'(b) == count_sat) begin
            msg_pad[8*b +: 8] = PAD_BYTE;
         end else begin
            msg_pad[8*b +: 8] = 8'h00;
         end
      end
   end

   assign h_in = H_W'(acc_ff) + H_W'(msg_pad[128:0]);

   // The multiplier walks the output columns in order, five products per column.
   assign mul_ctl_in.vld     = (state_ff == ST_MUL);
   assign mul_ctl_in.col_end = (row_ff == LAST_LIMB);
   assign mul_ctl_in.row     = row_ff;
   assign mul_ctl_in.col     = col_ff;

   p1305_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .h       (h_ff),
      .r       (r_clamped),
      .ctl_in  (mul_ctl_in),
      .prod    (mul_prod),
      .ctl_out (mul_ctl_out)
   );

   assign col_sum = col_acc_ff + COL_W'(mul_prod);

   // The carry out of the top column sits at weight 2^130, which is 5 modulo p.
   assign carry_fold = H_W'(red_ff)
      + (H_W'(col_acc_ff[CARRY_W-1:0]) << 2) + H_W'(col_acc_ff[CARRY_W-1:0]);
   // Adding five carries into bit 130 exactly when the value is at least p.
   assign plus_five  = fold_ff + H_W'(3'd5);

   assign tag      = acc_ff[127:0] + {s_high_ff, s_low_ff};
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_ff       <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         acc_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         // Column accumulation behind the multiplier's output register.
         if (mul_ctl_out.vld) begin
            if (mul_ctl_out.col_end) begin
               red_ff[mul_ctl_out.col * LIMB_W +: LIMB_W] <= col_sum[LIMB_W-1:0];
               col_acc_ff <= col_sum >> LIMB_W;
            end else begin
               col_acc_ff <= col_sum;
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  last_ff <= req_tlast;
                  if (count_sat == 5'd0) begin
                     // Empty request: nothing to absorb, only a tag if it is last.
                     state_ff <= req_tlast ? ST_EMIT : ST_IDLE;
                  end else begin
                     h_ff       <= h_in;
                     row_ff     <= '0;
                     col_ff     <= '0;
                     col_acc_ff <= '0;
                     state_ff   <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               if (row_ff == LAST_LIMB) begin
                  row_ff <= '0;
                  col_ff <= col_ff + 3'd1;
                  if (col_ff == LAST_LIMB) begin
                     state_ff <= ST_DRAIN;
                  end
               end else begin
                  row_ff <= row_ff + 3'd1;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FOLD1;
            end
            ST_FOLD1: begin
               fold_ff  <= carry_fold;
               state_ff <= ST_FOLD2;
            end
            ST_FOLD2: begin
               fold_ff  <= H_W'(fold_ff[ACC_W-1:0])
                  + (fold_ff[ACC_W] ? H_W'(3'd5) : H_W'(0));
               state_ff <= ST_FINAL;
            end
            ST_FINAL: begin
               acc_ff   <= plus_five[ACC_W] ? plus_five[ACC_W-1:0] : fold_ff[ACC_W-1:0];
               state_ff <= last_ff ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_tdata_ff  <= tag;
                  rsp_tvalid_ff <= 1'b1;
                  acc_ff        <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `P1305_CHECK(a_acc_reduced, acc_ff < P_MOD, "accumulator is not reduced below p")
   `P1305_CHECK(a_mul_drained, (state_ff != ST_FOLD1) || !mul_ctl_out.vld, "product pending at fold")
   `P1305_CHECK(a_carry_fits, (state_ff != ST_FOLD1) || (col_acc_ff[COL_W-1:CARRY_W] == '0), "top carry overflow")
   `P1305_CHECK(a_fold_bound, (state_ff != ST_FINAL) || !fold_ff[ACC_W] || (fold_ff[ACC_W-1:0] < 130'd5), "fold exceeds 2p")
   `P1305_NEXT(a_emit_clears, (state_ff == ST_EMIT) && out_free, (acc_ff == '0) && rsp_tvalid_ff, "tag load did not clear accumulator")

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Poly1305 MAC: directed rows, then random messages under stalls.
module tb;

   // The multiplier half r is clamped before use, and every product is reduced modulo
   // p = 2^130 - 5. The pause of SETTLE_CYCLES after the last tag outlasts one request in
   // the block, so no tagless request is still in flight.
   localparam logic [63:0]  R_MASK_LOW      = 64'h0FFF_FFFC_0FFF_FFFF;
   localparam logic [63:0]  R_MASK_HIGH     = 64'h0FFF_FFFC_0FFF_FFFC;
   localparam logic [255:0] PRIME_P         =
      {126'd0, 130'h3_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF_FFFB};
   localparam int           SETTLE_CYCLES   = 40;
   localparam int           HOLD_OFF_CYCLES = 2000;
   localparam int           PHASE_REQUESTS  = 225;
   localparam int           PRINT_LIMIT     = 50;

   typedef enum logic [1:0] {REG_R_LOW, REG_R_HIGH, REG_S_LOW, REG_S_HIGH} csr_index_e;
   typedef enum int {KEEP_KEY, SPEC_KEY, ONES_KEY} key_choice_e;

   typedef struct packed {
      logic [63:0] r_low;
      logic [63:0] r_high;
      logic [63:0] s_low;
      logic [63:0] s_high;
   } mac_key_t;

   // Packed so that tag_low sits in the low half, as on rsp_tdata.
   typedef struct packed {
      logic [63:0] tag_high;
      logic [63:0] tag_low;
   } tag_t;

   typedef struct {
      key_choice_e key;
      logic [63:0] blk_low;
      logic [63:0] blk_high;
      logic [4:0]  count;
      bit          last;
      bit          known;
      tag_t        tag;
   } directed_row_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // req_tdata from bit 0: block_low[63:0], block_high[63:0], byte_count[4:0], zero fill
   logic [135:0] req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // rsp_tdata from bit 0: tag_low[63:0], tag_high[63:0]
   logic [127:0] rsp_tdata;
   logic         csr_we;
   logic [1:0]   csr_addr;
   logic [63:0]  csr_wdata;

   // Our own copy of the key registers and of the 130-bit accumulator.
   mac_key_t      key_shadow;
   logic [129:0]  acc_shadow;
   tag_t          tags_due[$];
   directed_row_t directed_plan[$];

   int error_count    = 0;
   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int hold_asked     = 0;
   int hold_served    = 0;
   int hold_left      = 0;

   poly1305_mac dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: stops a run that hangs and reports it as failed.
   initial begin
      #(64'd8_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   // Pads one block at its byte count, adds it to the accumulator, multiplies by the
   // clamped r and reduces exactly modulo p.
   function automatic void absorb_block(input logic [127:0] data, input int nbytes);
      logic [127:0] keep;
      logic [255:0] padded;
      logic [255:0] r_clamped;
      logic [255:0] product;
      keep = (nbytes == 16) ? '1 : ((128'd1 << (8 * nbytes)) - 128'd1);
      padded = {128'd0, data & keep} | (256'd1 << (8 * nbytes));
      r_clamped = {128'd0, key_shadow.r_high & R_MASK_HIGH, key_shadow.r_low & R_MASK_LOW};
      product = ({126'd0, acc_shadow} + padded) * r_clamped;
      product = product % PRIME_P;
      acc_shadow = product[129:0];
   endfunction

   // Steps the predicted state by one request; returns 1 when a tag is due.
   function automatic bit predict_tag(input logic [63:0] lo, input logic [63:0] hi,
                                      input logic [4:0] count, input bit last,
                                      output tag_t tag);
      int nbytes;
      // Counts above sixteen mean a full block; a count of zero adds nothing.
      nbytes = (count > 5'd16) ? 16 : int'(count);
      tag = '0;
      if (nbytes != 0)
         absorb_block({hi, lo}, nbytes);
      if (!last)
         return 1'b0;
      tag = acc_shadow[127:0] + {key_shadow.s_high, key_shadow.s_low};
      acc_shadow = '0;
      return 1'b1;
   endfunction

   // Offers one request, with random idle cycles ahead of it, and predicts its tag
   // once it has been accepted. Valid stays high into the next request unless that
   // one starts with a gap, so valid is never lowered and raised in one time step.
   task automatic send_request(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] count, input bit last,
                               input bit known, input tag_t known_tag);
      tag_t tag;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, count, hi, lo};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (predict_tag(lo, hi, count, last, tag))
         tags_due.push_back(known ? known_tag : tag);
   endtask

   // Lets every expected tag arrive, then allows a tagless request to finish.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tags_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all four key registers on consecutive edges; the block must be idle.
   task automatic load_key(input mac_key_t k);
      csr_we    <= 1'b1;
      csr_addr  <= REG_R_LOW;
      csr_wdata <= k.r_low;
      @(posedge clock);
      csr_addr  <= REG_R_HIGH;
      csr_wdata <= k.r_high;
      @(posedge clock);
      csr_addr  <= REG_S_LOW;
      csr_wdata <= k.s_low;
      @(posedge clock);
      csr_addr  <= REG_S_HIGH;
      csr_wdata <= k.s_high;
      @(posedge clock);
      csr_we    <= 1'b0;
      key_shadow = k;
   endtask

   // Mostly random words, with all-zero and all-one words mixed in.
   function automatic logic [63:0] rand_word();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic mac_key_t random_key();
      mac_key_t k;
      k.r_low  = rand_word();
      k.r_high = rand_word();
      k.s_low  = rand_word();
      k.s_high = rand_word();
      return k;
   endfunction

   function automatic mac_key_t key_for(input key_choice_e choice);
      mac_key_t k;
      k = '1;
      if (choice == SPEC_KEY) begin
         k.r_low  = 64'h336D_5557_78BE_D685;
         k.r_high = 64'hA806_D542_FE52_447F;
         k.s_low  = 64'hFDB2_0DFB_8A80_0301;
         k.s_high = 64'h1BF5_4941_AFF6_BF4A;
      end
      return k;
   endfunction

   function automatic void add_row(input key_choice_e key, input logic [63:0] lo,
                                   input logic [63:0] hi, input logic [4:0] count,
                                   input bit last, input bit known,
                                   input logic [63:0] tag_low, input logic [63:0] tag_high);
      directed_row_t row;
      row.key      = key;
      row.blk_low  = lo;
      row.blk_high = hi;
      row.count    = count;
      row.last     = last;
      row.known    = known;
      row.tag      = {tag_high, tag_low};
      directed_plan.push_back(row);
   endfunction

   function automatic void build_directed_plan();
      // Reset key: r and s are both zero, so every tag comes out zero.
      add_row(KEEP_KEY, '1, '1, 5'd16, 1'b1, 1'b1, '0, '0);
      add_row(KEEP_KEY, '0, '0, 5'd0, 1'b1, 1'b1, '0, '0);
      add_row(KEEP_KEY, '1, '1, 5'd31, 1'b0, 1'b0, '0, '0);
      add_row(KEEP_KEY, '1, '0, 5'd5, 1'b1, 1'b1, '0, '0);
      // The published Poly1305 test vector, 34 bytes. Its last block carries junk past
      // its two valid bytes, which the block has to mask off.
      add_row(SPEC_KEY, 64'h7267_6F74_7079_7243, 64'h6F46_2063_6968_7061, 5'd16,
              1'b0, 1'b0, '0, '0);
      add_row(KEEP_KEY, 64'h6573_6552_206D_7572, 64'h6F72_4720_6863_7261, 5'd16,
              1'b0, 1'b0, '0, '0);
      add_row(KEEP_KEY, 64'hA5A5_5A5A_C3C3_7075, '1, 5'd2, 1'b1, 1'b1,
              64'hC636_5130_C11D_06A8, 64'hA927_010C_AF8B_2BC2);
      // An empty message right after a tag yields s itself.
      add_row(KEEP_KEY, '1, '1, 5'd0, 1'b1, 1'b1, 64'hFDB2_0DFB_8A80_0301,
              64'h1BF5_4941_AFF6_BF4A);
      // All-ones key: largest clamped r and largest s.
      add_row(ONES_KEY, '1, '1, 5'd0, 1'b0, 1'b0, '0, '0);
      add_row(KEEP_KEY, '1, '1, 5'd16, 1'b0, 1'b0, '0, '0);
      add_row(KEEP_KEY, '0, '0, 5'd17, 1'b0, 1'b0, '0, '0);
      add_row(KEEP_KEY, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd8,
              1'b0, 1'b0, '0, '0);
      add_row(KEEP_KEY, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FF80, 5'd9,
              1'b0, 1'b0, '0, '0);
      add_row(KEEP_KEY, '1, '1, 5'd1, 1'b0, 1'b0, '0, '0);
      add_row(KEEP_KEY, 64'hDEAD_BEEF_CAFE_F00D, 64'h5555_AAAA_3333_CCCC, 5'd15,
              1'b1, 1'b0, '0, '0);
      add_row(KEEP_KEY, '1, '1, 5'd0, 1'b1, 1'b1, '1, '1);
      add_row(KEEP_KEY, '0, '0, 5'd16, 1'b1, 1'b0, '0, '0);
      add_row(KEEP_KEY, 64'h7F7F_7F7F_7F7F_7F7F, '1, 5'd7, 1'b1, 1'b0, '0, '0);
      add_row(KEEP_KEY, '1, '1, 5'd31, 1'b1, 1'b0, '0, '0);
      add_row(KEEP_KEY, '1, '1, 5'd0, 1'b1, 1'b1, '1, '1);
   endfunction

   // Random messages: mostly whole 16-byte blocks closed by a short or full last block,
   // with some loose requests of any count and either tlast value in between. Empty
   // requests that are not last do nothing and are not counted.
   task automatic run_random_phase(input int requests);
      int         counted;
      int         full_blocks;
      logic [4:0] count;
      bit         last;
      counted = 0;
      while (counted < requests) begin
         if ($urandom_range(99) < 15) begin
            count = 5'($urandom_range(31));
            last  = 1'($urandom_range(1));
            send_request(rand_word(), rand_word(), count, last, 1'b0, '0);
            if (count != 5'd0 || last)
               counted++;
         end else begin
            full_blocks = ($urandom_range(15) == 0) ? $urandom_range(24) : $urandom_range(3);
            repeat (full_blocks) begin
               send_request(rand_word(), rand_word(), 5'd16, 1'b0, 1'b0, '0);
               counted++;
            end
            count = 5'($urandom_range(16));
            send_request(rand_word(), rand_word(), count, 1'b1, 1'b0, '0);
            counted++;
         end
      end
   endtask

   task automatic check_tag(input logic [127:0] data);
      tag_t want;
      if (tags_due.size() == 0) begin
         report_mismatch("tag with none pending", data[63:0], '0);
         return;
      end
      want = tags_due.pop_front();
      if (data[63:0] !== want.tag_low)
         report_mismatch("tag_low", data[63:0], want.tag_low);
      if (data[127:64] !== want.tag_high)
         report_mismatch("tag_high", data[127:64], want.tag_high);
   endtask

   // Receiver: checks every accepted tag and drives rsp_tready. A hold-off request
   // from the main sequence keeps ready low for a long, counted stretch.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid && rsp_tready)
               check_tag(rsp_tdata);
            if (hold_asked != hold_served) begin
               hold_served = hold_asked;
               hold_left   = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
         end
      end
   end

   // Main sequence: reset, the directed rows, then six random phases with different
   // keys and idling patterns. Keys change only once the block has gone idle.
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= REG_R_LOW;
      csr_wdata  <= '0;
      key_shadow = '0;
      acc_shadow = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      build_directed_plan();
      foreach (directed_plan[i]) begin
         if (directed_plan[i].key != KEEP_KEY) begin
            wait_idle();
            load_key(key_for(directed_plan[i].key));
         end
         send_request(directed_plan[i].blk_low, directed_plan[i].blk_high,
                      directed_plan[i].count, directed_plan[i].last,
                      directed_plan[i].known, directed_plan[i].tag);
      end
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               // Back to back in both directions, all-ones key.
               send_gap_pct   = 0;
               recv_stall_pct = 0;
               load_key(key_for(ONES_KEY));
            end
            1: begin
               // Sender idles often; all-zero key.
               send_gap_pct   = 52;
               recv_stall_pct = 0;
               load_key('0);
            end
            2: begin
               send_gap_pct   = 0;
               recv_stall_pct = 52;
               load_key(random_key());
            end
            4: begin
               // Sender keeps offering while the receiver holds off for a long time,
               // so the tag register fills and the request side stalls.
               send_gap_pct   = 0;
               recv_stall_pct = 0;
               load_key(random_key());
               hold_asked++;
            end
            default: begin
               send_gap_pct   = 26;
               recv_stall_pct = 26;
               load_key(random_key());
            end
         endcase
         run_random_phase(PHASE_REQUESTS);
         wait_idle();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
